@@ design/s3beq_pkg.sv @@
// Shared constants, types and saturation helper for the stereo three-band equalizer.
// No dependencies; used by s3beq_lane, s3beq_cell, stereo_three_band_biquad_eq_core, stereo_eq_checker and tb.
`timescale 1ns / 1ps
`default_nettype none

package s3beq_pkg;

  // Sample, signal and coefficient formats.
  localparam int SAMPLE_W  = 16;  // signed PCM sample
  localparam int SIG_W     = 32;  // signal and delays, Q4.27
  localparam int COEF_W    = 24;  // coefficient, Q3.20
  localparam int COEF_FRAC = 20;
  localparam int IN_SHIFT  = 12;  // PCM sample to Q27
  localparam int SIG_FRAC  = 27;
  localparam int PROD_W    = COEF_W + SIG_W;      // exact product
  localparam int TERM_W    = PROD_W - COEF_FRAC;  // product after floor shift
  localparam int ACC_W     = TERM_W + 2;          // room for three terms

  // Output conversion.
  localparam int                 MAG_W     = 27;
  localparam logic [MAG_W-1:0]   CLAMP_Q27 = MAG_W'(131533373);  // 0.98 in Q27
  localparam int                 SCALE_W   = 15;
  localparam logic [SCALE_W-1:0] OUT_SCALE = SCALE_W'(32767);

  // Configuration port.
  localparam int                     CFG_INDEX_W  = 5;
  localparam int                     CFG_DATA_W   = 48;
  localparam logic [CFG_INDEX_W-1:0] ENABLE_INDEX = '0;
  localparam logic [CFG_DATA_W-1:0]  FF_RESET     = CFG_DATA_W'(1048576);  // b0 = 1.0
  localparam logic [CFG_DATA_W-1:0]  FB_RESET     = '0;

  localparam int DEFAULT_BAND_COUNT = 3;

  // Sequencer steps of one band; each names the product formed in that cycle.
  localparam int             STEP_W   = 3;
  localparam logic [STEP_W-1:0] STEP_B0X = 3'd0;
  localparam logic [STEP_W-1:0] STEP_B1X = 3'd1;
  localparam logic [STEP_W-1:0] STEP_B1Y = 3'd2;
  localparam logic [STEP_W-1:0] STEP_B2X = 3'd3;
  localparam logic [STEP_W-1:0] STEP_A2Y = 3'd4;
  localparam logic [STEP_W-1:0] STEP_Z2  = 3'd5;  // last step, no new product

  typedef struct packed {
    logic                   we;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
    logic                   clear;  // valid index written: delays go to zero
  } cfg_t;

  typedef struct packed {
    logic              start;  // latch the band input
    logic              pass;   // band disabled: output equals input
    logic              run;
    logic [STEP_W-1:0] step;
    logic              clear;
  } lane_ctl_t;

  // Saturate a wide sum to the signed 32-bit range.
  function automatic logic signed [SIG_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'({1'b0, {(SIG_W-1){1'b1}}});
    lo = -hi - ACC_W'(1);
    if (v > hi) begin
      sat32 = {1'b0, {(SIG_W-1){1'b1}}};
    end else if (v < lo) begin
      sat32 = {1'b1, {(SIG_W-1){1'b0}}};
    end else begin
      sat32 = v[SIG_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

@@ design/stereo_three_band_biquad_eq_core.sv @@
// Top level of the stereo equalizer: stream ports, configuration, band cascade, PCM output.
// Depends on s3beq_pkg and s3beq_cell (which uses s3beq_lane).
//
//   Channel   Dir  Handshake          Payload
//   s_*       in   s_tvalid/s_tready  s_tdata[15:0] left_in, [31:16] right_in
//   m_*       out  m_tvalid/m_tready  m_tdata[15:0] left_out, [31:16] right_out
//   cfg_*     in   cfg_we             cfg_index, cfg_data (write only)
//
// A band cell latches its input; an enabled band then runs six steps on its single multiplier
// per channel (five products and the last delay update), and a disabled band passes its input
// straight on. The core then clamps (ST_CLAMP), converts to PCM and loads the output beat
// (ST_SCALE) once the output register is free, and returns to idle, where the next input
// beat can be taken.
// Frames are handled one at a time; s_tready is high whenever the core is idle, even
// while the previous result still waits in the output register for m_tready.
// rst is synchronous and active high; it restores the register defaults and zeroes
// every delay. Any write to a valid register index also zeroes the delays.
`timescale 1ns / 1ps
`default_nettype none

module stereo_three_band_biquad_eq_core #(
  parameter int BAND_COUNT = s3beq_pkg::DEFAULT_BAND_COUNT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Input beat: left_in [15:0], right_in [31:16].
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [2*s3beq_pkg::SAMPLE_W-1:0]    s_tdata,
  // Output beat: left_out [15:0], right_out [31:16].
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [2*s3beq_pkg::SAMPLE_W-1:0]         m_tdata,
  input  wire logic                                cfg_we,
  input  wire logic [s3beq_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [s3beq_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam logic [s3beq_pkg::CFG_INDEX_W-1:0] LAST_INDEX =
    s3beq_pkg::CFG_INDEX_W'(2 * BAND_COUNT);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_CLAMP,
    ST_SCALE
  } state_t;

  state_t                                 state;
  logic [BAND_COUNT-1:0]                  band_enable;
  s3beq_pkg::cfg_t                        cfg;

  // Captured samples, kept for the bypass case.
  logic signed [s3beq_pkg::SAMPLE_W-1:0]  raw_l;
  logic signed [s3beq_pkg::SAMPLE_W-1:0]  raw_r;
  logic                                   chain_start;

  // Cascade links: entry n feeds cell n, the last entry is the cascade output.
  logic                                   link_done [BAND_COUNT+1];
  logic signed [s3beq_pkg::SIG_W-1:0]     link_l    [BAND_COUNT+1];
  logic signed [s3beq_pkg::SIG_W-1:0]     link_r    [BAND_COUNT+1];

  // Output conversion registers: clamped magnitude and sign per channel.
  logic [s3beq_pkg::MAG_W-1:0]            mag_l;
  logic [s3beq_pkg::MAG_W-1:0]            mag_r;
  logic                                   neg_l;
  logic                                   neg_r;

  logic [s3beq_pkg::SIG_W-1:0]            abs_l;
  logic [s3beq_pkg::SIG_W-1:0]            abs_r;
  logic [s3beq_pkg::MAG_W+s3beq_pkg::SCALE_W-1:0] scaled_l;
  logic [s3beq_pkg::MAG_W+s3beq_pkg::SCALE_W-1:0] scaled_r;
  logic [s3beq_pkg::SAMPLE_W-1:0]         pcm_l;
  logic [s3beq_pkg::SAMPLE_W-1:0]         pcm_r;
  logic [s3beq_pkg::SAMPLE_W-1:0]         out_l;
  logic [s3beq_pkg::SAMPLE_W-1:0]         out_r;
  logic                                   out_free;

  // Configuration broadcast; a write to any valid index clears all delays.
  always_comb begin
    cfg.we    = cfg_we;
    cfg.index = cfg_index;
    cfg.data  = cfg_data;
    cfg.clear = cfg_we && (cfg_index <= LAST_INDEX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      band_enable <= '0;
    end else if (cfg_we && cfg_index == s3beq_pkg::ENABLE_INDEX) begin
      band_enable <= cfg_data[BAND_COUNT-1:0];
    end
  end

  // Samples enter the cascade in Q27, the sample shifted up by twelve bits.
  assign link_done[0] = chain_start;
  assign link_l[0]    = s3beq_pkg::SIG_W'(raw_l) <<< s3beq_pkg::IN_SHIFT;
  assign link_r[0]    = s3beq_pkg::SIG_W'(raw_r) <<< s3beq_pkg::IN_SHIFT;

  for (genvar n = 0; n < BAND_COUNT; n++) begin : g_band
    s3beq_cell #(
      .CELL_INDEX (n)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .cfg    (cfg),
      .enable (band_enable[n]),
      .start  (link_done[n]),
      .x_l    (link_l[n]),
      .x_r    (link_r[n]),
      .done   (link_done[n+1]),
      .y_l    (link_l[n+1]),
      .y_r    (link_r[n+1])
    );
  end

  // Magnitude of the cascade output; the most negative value maps to 2^31 unsigned.
  assign abs_l = link_l[BAND_COUNT][s3beq_pkg::SIG_W-1] ?
                 s3beq_pkg::SIG_W'(-link_l[BAND_COUNT]) : link_l[BAND_COUNT];
  assign abs_r = link_r[BAND_COUNT][s3beq_pkg::SIG_W-1] ?
                 s3beq_pkg::SIG_W'(-link_r[BAND_COUNT]) : link_r[BAND_COUNT];

  // Scale by 32767 and drop 27 fraction bits, then restore the sign.
  assign scaled_l = s3beq_pkg::OUT_SCALE * mag_l;
  assign scaled_r = s3beq_pkg::OUT_SCALE * mag_r;
  assign pcm_l = neg_l ?
    s3beq_pkg::SAMPLE_W'(-{1'b0, scaled_l[s3beq_pkg::SIG_FRAC +: s3beq_pkg::SCALE_W]}) :
    s3beq_pkg::SAMPLE_W'(scaled_l[s3beq_pkg::SIG_FRAC +: s3beq_pkg::SCALE_W]);
  assign pcm_r = neg_r ?
    s3beq_pkg::SAMPLE_W'(-{1'b0, scaled_r[s3beq_pkg::SIG_FRAC +: s3beq_pkg::SCALE_W]}) :
    s3beq_pkg::SAMPLE_W'(scaled_r[s3beq_pkg::SIG_FRAC +: s3beq_pkg::SCALE_W]);

  // With no band enabled the captured samples go out untouched.
  assign out_l    = (band_enable == '0) ? raw_l : pcm_l;
  assign out_r    = (band_enable == '0) ? raw_r : pcm_r;
  assign out_free = ~m_tvalid | m_tready;

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      chain_start <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      chain_start <= 1'b0;
      // The output register loads when it is empty or its beat leaves in this cycle.
      if (state == ST_SCALE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            raw_l       <= s_tdata[s3beq_pkg::SAMPLE_W-1:0];
            raw_r       <= s_tdata[2*s3beq_pkg::SAMPLE_W-1:s3beq_pkg::SAMPLE_W];
            chain_start <= 1'b1;
            state       <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (link_done[BAND_COUNT]) begin
            state <= ST_CLAMP;
          end
        end
        ST_CLAMP: begin
          neg_l <= link_l[BAND_COUNT][s3beq_pkg::SIG_W-1];
          neg_r <= link_r[BAND_COUNT][s3beq_pkg::SIG_W-1];
          mag_l <= (abs_l > s3beq_pkg::SIG_W'(s3beq_pkg::CLAMP_Q27)) ?
                   s3beq_pkg::CLAMP_Q27 : abs_l[s3beq_pkg::MAG_W-1:0];
          mag_r <= (abs_r > s3beq_pkg::SIG_W'(s3beq_pkg::CLAMP_Q27)) ?
                   s3beq_pkg::CLAMP_Q27 : abs_r[s3beq_pkg::MAG_W-1:0];
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          if (out_free) begin
            m_tdata <= {out_r, out_l};
            state   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/s3beq_lane.sv @@
// One channel of one band: delay pair, multiplier and accumulator of a TDF-II biquad.
// Depends on s3beq_pkg; sequenced by s3beq_cell.
`timescale 1ns / 1ps
`default_nettype none

module s3beq_lane (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire s3beq_pkg::lane_ctl_t                   ctl,
  input  wire logic signed [s3beq_pkg::SIG_W-1:0]     x_in,
  input  wire logic signed [s3beq_pkg::COEF_W-1:0]    b0,
  input  wire logic signed [s3beq_pkg::COEF_W-1:0]    b1,
  input  wire logic signed [s3beq_pkg::COEF_W-1:0]    b2,
  input  wire logic signed [s3beq_pkg::COEF_W-1:0]    a2,
  output logic signed [s3beq_pkg::SIG_W-1:0]          y
);

  logic signed [s3beq_pkg::SIG_W-1:0]  x;
  logic signed [s3beq_pkg::SIG_W-1:0]  z1;
  logic signed [s3beq_pkg::SIG_W-1:0]  z2;
  logic signed [s3beq_pkg::TERM_W-1:0] mterm;
  logic signed [s3beq_pkg::ACC_W-1:0]  acc;

  logic signed [s3beq_pkg::COEF_W-1:0] mcoef;
  logic signed [s3beq_pkg::SIG_W-1:0]  mdata;
  logic signed [s3beq_pkg::PROD_W-1:0] prod;
  logic signed [s3beq_pkg::ACC_W-1:0]  term_ext;
  logic signed [s3beq_pkg::ACC_W-1:0]  z1_ext;
  logic signed [s3beq_pkg::ACC_W-1:0]  z2_ext;

  always_comb begin
    case (ctl.step)
      s3beq_pkg::STEP_B0X: begin
        mcoef = b0;
        mdata = x;
      end
      s3beq_pkg::STEP_B1X: begin
        mcoef = b1;
        mdata = x;
      end
      s3beq_pkg::STEP_B1Y: begin
        mcoef = b1;
        mdata = y;
      end
      s3beq_pkg::STEP_B2X: begin
        mcoef = b2;
        mdata = x;
      end
      s3beq_pkg::STEP_A2Y: begin
        mcoef = a2;
        mdata = y;
      end
      default: begin
        mcoef = b0;
        mdata = x;
      end
    endcase
  end

  // Dropping the low bits of the two's complement product is a floor shift.
  assign prod     = mcoef * mdata;
  assign term_ext = s3beq_pkg::ACC_W'(mterm);
  assign z1_ext   = s3beq_pkg::ACC_W'(z1);
  assign z2_ext   = s3beq_pkg::ACC_W'(z2);

  // Each cycle consumes the product registered in the cycle before.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      x <= x_in;
      if (ctl.pass) begin
        y <= x_in;
      end
    end
    if (ctl.run) begin
      mterm <= prod[s3beq_pkg::PROD_W-1:s3beq_pkg::COEF_FRAC];
      case (ctl.step)
        s3beq_pkg::STEP_B1X: y   <= s3beq_pkg::sat32(term_ext + z1_ext);
        s3beq_pkg::STEP_B1Y: acc <= term_ext + z2_ext;
        s3beq_pkg::STEP_A2Y: acc <= term_ext;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      z1 <= '0;
      z2 <= '0;
    end else if (ctl.run) begin
      case (ctl.step)
        s3beq_pkg::STEP_B2X: z1 <= s3beq_pkg::sat32(acc - term_ext);
        s3beq_pkg::STEP_Z2:  z2 <= s3beq_pkg::sat32(acc - term_ext);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/s3beq_cell.sv @@
// One band of the cascade: coefficient registers, step sequencer and two channel lanes.
// Depends on s3beq_pkg and s3beq_lane.
`timescale 1ns / 1ps
`default_nettype none

module s3beq_cell #(
  parameter int CELL_INDEX = 0
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire s3beq_pkg::cfg_t                       cfg,
  input  wire logic                                  enable,
  input  wire logic                                  start,
  input  wire logic signed [s3beq_pkg::SIG_W-1:0]    x_l,
  input  wire logic signed [s3beq_pkg::SIG_W-1:0]    x_r,
  output logic                                       done,
  output logic signed [s3beq_pkg::SIG_W-1:0]         y_l,
  output logic signed [s3beq_pkg::SIG_W-1:0]         y_r
);

  localparam logic [s3beq_pkg::CFG_INDEX_W-1:0] FF_INDEX =
    s3beq_pkg::CFG_INDEX_W'(1 + 2 * CELL_INDEX);
  localparam logic [s3beq_pkg::CFG_INDEX_W-1:0] FB_INDEX =
    s3beq_pkg::CFG_INDEX_W'(2 + 2 * CELL_INDEX);

  logic [s3beq_pkg::CFG_DATA_W-1:0] ff;
  logic [s3beq_pkg::CFG_DATA_W-1:0] fb;
  logic                             run;
  logic [s3beq_pkg::STEP_W-1:0]     step;
  s3beq_pkg::lane_ctl_t             ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      ff   <= s3beq_pkg::FF_RESET;
      fb   <= s3beq_pkg::FB_RESET;
      run  <= 1'b0;
      step <= s3beq_pkg::STEP_B0X;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg.we && cfg.index == FF_INDEX) begin
        ff <= cfg.data;
      end
      if (cfg.we && cfg.index == FB_INDEX) begin
        fb <= cfg.data;
      end
      if (start) begin
        if (enable) begin
          run  <= 1'b1;
          step <= s3beq_pkg::STEP_B0X;
        end else begin
          done <= 1'b1;
        end
      end else if (run) begin
        if (step == s3beq_pkg::STEP_Z2) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  always_comb begin
    ctl.start = start;
    ctl.pass  = ~enable;
    ctl.run   = run;
    ctl.step  = step;
    ctl.clear = cfg.clear;
  end

  s3beq_lane u_lane_l (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .x_in (x_l),
    .b0   (ff[23:0]),
    .b1   (fb[23:0]),
    .b2   (ff[47:24]),
    .a2   (fb[47:24]),
    .y    (y_l)
  );

  s3beq_lane u_lane_r (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .x_in (x_r),
    .b0   (ff[23:0]),
    .b1   (fb[23:0]),
    .b2   (ff[47:24]),
    .a2   (fb[47:24]),
    .y    (y_r)
  );

endmodule

`default_nettype wire

@@ verif/stereo_eq_checker.sv @@
// Checker for the stereo three-band equalizer: mirrors the register writes, predicts each
// output frame from the accepted input frames and compares the output beats against them.
// Depends on s3beq_pkg for the sample, signal and configuration formats.
`timescale 1ns / 1ps

module stereo_eq_checker #(
  parameter int BAND_COUNT = s3beq_pkg::DEFAULT_BAND_COUNT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  input  logic                                   s_tready,
  input  logic [2*s3beq_pkg::SAMPLE_W-1:0]       s_tdata,
  input  logic                                   m_tvalid,
  input  logic                                   m_tready,
  input  logic [2*s3beq_pkg::SAMPLE_W-1:0]       m_tdata,
  input  logic                                   cfg_we,
  input  logic [s3beq_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [s3beq_pkg::CFG_DATA_W-1:0]       cfg_data,
  output int                                     mismatch_count,
  output int                                     frames_in_flight,
  output int                                     frames_checked
);

  import s3beq_pkg::*;

  typedef logic signed [SIG_W-1:0] q27_t;
  typedef logic signed [63:0]      wide_t;

  localparam wide_t SIG_MAX    = 64'sd2147483647;
  localparam wide_t SIG_MIN    = -64'sd2147483648;
  localparam int    LAST_INDEX = 2 * BAND_COUNT;
  localparam int    LEFT       = 0;
  localparam int    RIGHT      = 1;

  logic [BAND_COUNT-1:0]   band_on;
  logic [CFG_DATA_W-1:0]   ff_coef [BAND_COUNT];
  logic [CFG_DATA_W-1:0]   fb_coef [BAND_COUNT];
  q27_t                    z1 [2][BAND_COUNT];
  q27_t                    z2 [2][BAND_COUNT];
  logic [2*SAMPLE_W-1:0]   expected_pcm_q [$];

  function automatic void clear_delays();
    for (int ch = 0; ch < 2; ch++) begin
      for (int n = 0; n < BAND_COUNT; n++) begin
        z1[ch][n] = '0;
        z2[ch][n] = '0;
      end
    end
  endfunction

  // Coefficient times signal, shifted down to Q27 with rounding toward minus infinity.
  function automatic wide_t coef_times(input logic [COEF_W-1:0] c, input q27_t s);
    wide_t cw;
    wide_t sw;
    cw = $signed(c);
    sw = s;
    return (cw * sw) >>> COEF_FRAC;
  endfunction

  function automatic q27_t clip_sig(input wide_t v);
    if (v > SIG_MAX) return SIG_MAX[SIG_W-1:0];
    if (v < SIG_MIN) return SIG_MIN[SIG_W-1:0];
    return v[SIG_W-1:0];
  endfunction

  function automatic q27_t filter_band(input int ch, input int n, input q27_t x);
    logic [COEF_W-1:0] b0;
    logic [COEF_W-1:0] b2;
    logic [COEF_W-1:0] b1;
    logic [COEF_W-1:0] a2;
    wide_t             zw1;
    wide_t             zw2;
    q27_t              y;
    b0  = ff_coef[n][COEF_W-1:0];
    b2  = ff_coef[n][2*COEF_W-1:COEF_W];
    b1  = fb_coef[n][COEF_W-1:0];
    a2  = fb_coef[n][2*COEF_W-1:COEF_W];
    zw1 = z1[ch][n];
    zw2 = z2[ch][n];
    y   = clip_sig(coef_times(b0, x) + zw1);
    // Peaking sections share one value for b1 and a1.
    z1[ch][n] = clip_sig(coef_times(b1, x) - coef_times(b1, y) + zw2);
    z2[ch][n] = clip_sig(coef_times(b2, x) - coef_times(a2, y));
    return y;
  endfunction

  // Clamp to 0.98 and scale by 32767, truncating the magnitude.
  function automatic logic [SAMPLE_W-1:0] to_pcm(input q27_t v);
    wide_t m;
    wide_t lim;
    logic  neg;
    lim = CLAMP_Q27;
    m   = v;
    neg = (m < 0);
    if (neg) m = -m;
    if (m > lim) m = lim;
    m = (m * 32767) >>> SIG_FRAC;
    if (neg) m = -m;
    return m[SAMPLE_W-1:0];
  endfunction

  function automatic logic [2*SAMPLE_W-1:0] equalize_frame(input logic [2*SAMPLE_W-1:0] din);
    logic [SAMPLE_W-1:0] ls;
    logic [SAMPLE_W-1:0] rs;
    q27_t                l;
    q27_t                r;
    if (band_on == '0) return din;
    ls = din[SAMPLE_W-1:0];
    rs = din[2*SAMPLE_W-1:SAMPLE_W];
    l  = {{(SIG_W-SAMPLE_W-IN_SHIFT){ls[SAMPLE_W-1]}}, ls, {IN_SHIFT{1'b0}}};
    r  = {{(SIG_W-SAMPLE_W-IN_SHIFT){rs[SAMPLE_W-1]}}, rs, {IN_SHIFT{1'b0}}};
    for (int n = 0; n < BAND_COUNT; n++) begin
      if (band_on[n]) begin
        l = filter_band(LEFT, n, l);
        r = filter_band(RIGHT, n, r);
      end
    end
    return {to_pcm(r), to_pcm(l)};
  endfunction

  always @(posedge clk) begin : watch
    logic [2*SAMPLE_W-1:0] want;
    int                    errs;
    int                    n;
    errs = 0;
    if (rst) begin
      band_on = '0;
      for (n = 0; n < BAND_COUNT; n++) begin
        ff_coef[n] = FF_RESET;
        fb_coef[n] = FB_RESET;
      end
      clear_delays();
      expected_pcm_q.delete();
      mismatch_count   <= 0;
      frames_checked   <= 0;
      frames_in_flight <= 0;
    end else begin
      // Output side first: a frame accepted in this cycle cannot leave in the same one.
      if (m_tvalid && m_tready) begin
        if (expected_pcm_q.size() == 0) begin
          $display("%0t: output beat with nothing expected, expected none, got %h",
                   $time, m_tdata);
          errs++;
        end else begin
          want = expected_pcm_q.pop_front();
          if (m_tdata[SAMPLE_W-1:0] !== want[SAMPLE_W-1:0]) begin
            $display("%0t: left_out mismatch, expected %0d, got %0d", $time,
                     $signed(want[SAMPLE_W-1:0]), $signed(m_tdata[SAMPLE_W-1:0]));
            errs++;
          end
          if (m_tdata[2*SAMPLE_W-1:SAMPLE_W] !== want[2*SAMPLE_W-1:SAMPLE_W]) begin
            $display("%0t: right_out mismatch, expected %0d, got %0d", $time,
                     $signed(want[2*SAMPLE_W-1:SAMPLE_W]),
                     $signed(m_tdata[2*SAMPLE_W-1:SAMPLE_W]));
            errs++;
          end
          frames_checked <= frames_checked + 1;
        end
      end

      // A write to any valid index zeroes every delay; other indexes are ignored.
      if (cfg_we) begin
        if (cfg_index == ENABLE_INDEX) begin
          band_on = cfg_data[BAND_COUNT-1:0];
          clear_delays();
        end else if (cfg_index <= LAST_INDEX) begin
          n = (cfg_index - 1) >> 1;
          if (cfg_index[0]) ff_coef[n] = cfg_data;
          else fb_coef[n] = cfg_data;
          clear_delays();
        end
      end

      if (s_tvalid && s_tready) expected_pcm_q.push_back(equalize_frame(s_tdata));

      if (errs != 0) mismatch_count <= mismatch_count + errs;
      frames_in_flight <= expected_pcm_q.size();
    end
  end

endmodule

@@ verif/tb.sv @@
// Top of the equalizer testbench: clock, reset, input frames, register writes and the verdict.
// Depends on s3beq_pkg, stereo_three_band_biquad_eq_core and stereo_eq_checker.
`timescale 1ns / 1ps

module tb;

  import s3beq_pkg::*;

  localparam int BANDS = DEFAULT_BAND_COUNT;

  typedef enum int {BASS = 0, MID = 1, TREBLE = 2} band_e;

  // Indexes past the last register: the first unused one and the top of the index field.
  localparam logic [CFG_INDEX_W-1:0] FIRST_UNUSED_INDEX = CFG_INDEX_W'(2 * BANDS + 1);
  localparam logic [CFG_INDEX_W-1:0] TOP_INDEX          = '1;

  // Q3.20 coefficient landmarks.
  localparam logic [COEF_W-1:0] COEF_ONE  = 24'h100000;
  localparam logic [COEF_W-1:0] COEF_MAX  = 24'h7FFFFF;
  localparam logic [COEF_W-1:0] COEF_MIN  = 24'h800000;
  localparam logic [COEF_W-1:0] COEF_ZERO = 24'h000000;

  localparam int RANDOM_SETTINGS    = 12;
  localparam int FRAMES_PER_SETTING = 50;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [2*SAMPLE_W-1:0]   s_tdata = '0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [2*SAMPLE_W-1:0]   m_tdata;
  logic                    cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  // While quiet is set neither side idles, so frames run back to back.
  logic quiet = 1'b0;
  int   ready_hold = 0;
  int   settings_seen = 0;

  int mismatch_count;
  int frames_in_flight;
  int frames_checked;

  always #5 clk = ~clk;

  stereo_three_band_biquad_eq_core uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  stereo_eq_checker #(
    .BAND_COUNT (BANDS)
  ) eq_check (
    .clk              (clk),
    .rst              (rst),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatch_count   (mismatch_count),
    .frames_in_flight (frames_in_flight),
    .frames_checked   (frames_checked)
  );

  // Idle stretches: mostly none or a few cycles, now and then a long one.
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0: return 16'h8000;
        1: return 16'h7FFF;
        2: return 16'h0000;
        default: return 16'hFFFF;
      endcase
    end
    // Quiet material keeps the filters out of saturation for a while.
    if (r < 3) return SAMPLE_W'($signed($urandom_range(0, 1023)) - 512);
    return SAMPLE_W'($urandom);
  endfunction

  function automatic logic [COEF_W-1:0] coef_extreme();
    case ($urandom_range(0, 4))
      0: return COEF_MAX;
      1: return COEF_MIN;
      2: return COEF_ZERO;
      3: return COEF_ONE;
      default: return 24'hFFFFFF;
    endcase
  endfunction

  function automatic logic [CFG_INDEX_W-1:0] ff_index(input int n);
    return CFG_INDEX_W'(1 + 2 * n);
  endfunction

  function automatic logic [CFG_INDEX_W-1:0] fb_index(input int n);
    return CFG_INDEX_W'(2 + 2 * n);
  endfunction

  // Most bands get a stable peaking section (b0 + b2 = 1 + a2, |a1| < 1 + a2);
  // the rest get arbitrary or extreme coefficients that drive the sums into saturation.
  task automatic pick_band(output logic [CFG_DATA_W-1:0] ff, output logic [CFG_DATA_W-1:0] fb);
    int kind;
    int a1;
    int a2;
    int b0;
    int b2;
    int lim;
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      a2  = $urandom_range(262144, 996147);
      lim = 1048576 + a2 - 16384;
      a1  = $urandom_range(0, lim);
      if ($urandom_range(0, 1) != 0) a1 = -a1;
      b0  = $urandom_range(524288, 2097152);
      b2  = 1048576 + a2 - b0;
      ff  = {b2[COEF_W-1:0], b0[COEF_W-1:0]};
      fb  = {a2[COEF_W-1:0], a1[COEF_W-1:0]};
    end else if (kind < 9) begin
      ff = CFG_DATA_W'({$urandom, $urandom});
      fb = CFG_DATA_W'({$urandom, $urandom});
    end else begin
      ff = {coef_extreme(), coef_extreme()};
      fb = {coef_extreme(), coef_extreme()};
    end
  endtask

  // One input beat. A gap, if any, comes first; valid stays high across back-to-back beats.
  task automatic send_frame(input logic [SAMPLE_W-1:0] left, input logic [SAMPLE_W-1:0] right);
    int gap;
    gap = quiet ? 0 : pause_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {right, left};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_batch(input int count);
    for (int i = 0; i < count; i++) send_frame(rand_sample(), rand_sample());
  endtask

  // Lowers valid and waits until every predicted frame has come out, so the core is idle.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (frames_in_flight != 0);
    settings_seen++;
  endtask

  // Writes go out one per cycle; cfg_close drops the enable after the last one.
  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic cfg_close();
    cfg_we <= 1'b0;
  endtask

  // The output side stalls on its own schedule, independent of the input side.
  always @(posedge clk) begin
    if (quiet) begin
      m_tready   <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      m_tready   <= ($urandom_range(0, 2) != 0);
      ready_hold <= pause_len();
    end
  end

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] ff;
    logic [CFG_DATA_W-1:0] fb;
    logic [CFG_DATA_W-1:0] en_data;
    band_e                 b;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset state has every band off, so the samples must pass through untouched.
    send_frame(16'h8000, 16'h7FFF);
    send_frame(16'h7FFF, 16'h8000);
    send_frame(16'h5555, 16'hAAAA);
    send_frame(16'h0000, 16'hFFFF);

    // All bands on with unity sections: shows the clamp at full scale and the
    // truncation toward zero for small values.
    wait_idle();
    cfg_write(ENABLE_INDEX, CFG_DATA_W'(7));
    for (int n = 0; n < BANDS; n++) begin
      cfg_write(ff_index(n), FF_RESET);
      cfg_write(fb_index(n), FB_RESET);
    end
    cfg_close();
    send_frame(16'h7FFF, 16'h8000);
    send_frame(16'h0000, 16'hFFFF);
    send_frame(16'h0001, 16'hC180);
    send_frame(16'h3E80, 16'hC180);

    // Bass alone with the largest coefficients of both signs, driving the sums into saturation.
    wait_idle();
    b = BASS;
    cfg_write(ENABLE_INDEX, CFG_DATA_W'(1 << b));
    cfg_write(ff_index(b), {COEF_MIN, COEF_MAX});
    cfg_write(fb_index(b), {COEF_MIN, COEF_MAX});
    cfg_close();
    send_frame(16'h7FFF, 16'h8000);
    send_frame(16'h8000, 16'h7FFF);
    send_frame(16'h7FFF, 16'h7FFF);
    send_frame(16'h8000, 16'h8000);

    // Mid and treble on; the enable word also carries set bits above the bands.
    wait_idle();
    cfg_write(ENABLE_INDEX, 48'hFFFF_FFFF_FFFE);
    cfg_write(ff_index(MID), {COEF_MAX, COEF_MIN});
    cfg_write(fb_index(MID), {COEF_MAX, COEF_MIN});
    cfg_write(ff_index(TREBLE), {COEF_ZERO, COEF_ONE});
    cfg_write(fb_index(TREBLE), {COEF_ZERO, COEF_ZERO});
    cfg_close();
    send_frame(16'h4000, 16'hC000);
    send_frame(16'h7FFF, 16'h8000);
    send_frame(16'h0123, 16'hFEDC);

    // Only bits above the bands set: nothing is enabled, so this is bypass again.
    wait_idle();
    cfg_write(ENABLE_INDEX, 48'h8000_0000_0008);
    cfg_close();
    send_frame(16'h1234, 16'hEDCC);
    send_frame(16'h8000, 16'h7FFF);

    // Writes past the last register must neither change a setting nor clear the delays,
    // so the filters carry their state across them.
    wait_idle();
    cfg_write(ENABLE_INDEX, CFG_DATA_W'(7));
    for (int n = 0; n < BANDS; n++) begin
      pick_band(ff, fb);
      cfg_write(ff_index(n), ff);
      cfg_write(fb_index(n), fb);
    end
    cfg_close();
    send_frame(16'h2000, 16'hE000);
    send_frame(16'h7FFF, 16'h8000);
    send_frame(16'h0000, 16'h0000);
    wait_idle();
    cfg_write(FIRST_UNUSED_INDEX, CFG_DATA_W'({$urandom, $urandom}));
    cfg_write(TOP_INDEX, CFG_DATA_W'({$urandom, $urandom}));
    cfg_close();
    send_frame(16'h0000, 16'h0000);
    send_frame(16'h1000, 16'hF000);
    send_frame(16'h0000, 16'h0000);

    // Random settings, each followed by a run of random frames. Every fourth run has
    // no idling on either side.
    for (int p = 0; p < RANDOM_SETTINGS; p++) begin
      wait_idle();
      quiet   <= (p % 4 == 3);
      en_data = CFG_DATA_W'({$urandom, $urandom});
      en_data[BANDS-1:0] = ($urandom_range(0, 5) == 0) ? '0 : BANDS'($urandom_range(1, 7));
      cfg_write(ENABLE_INDEX, en_data);
      for (int n = 0; n < BANDS; n++) begin
        if ($urandom_range(0, 3) != 0) begin
          pick_band(ff, fb);
          cfg_write(ff_index(n), ff);
          cfg_write(fb_index(n), fb);
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        cfg_write(CFG_INDEX_W'($urandom_range(2 * BANDS + 1, (1 << CFG_INDEX_W) - 1)),
                  CFG_DATA_W'({$urandom, $urandom}));
      end
      cfg_close();
      send_batch(FRAMES_PER_SETTING);
    end

    wait_idle();
    repeat (40) @(posedge clk);

    $display("Checked %0d stereo frames under %0d register settings, covering bypass,",
             frames_checked, settings_seen);
    $display("unity and extreme coefficients, saturation, clamping and ignored writes.");
    if (mismatch_count == 0 && frames_in_flight == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin : watchdog
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
design/s3beq_pkg.sv
design/s3beq_lane.sv
design/s3beq_cell.sv
design/stereo_three_band_biquad_eq_core.sv
verif/stereo_eq_checker.sv
verif/tb.sv
